>>> design/depth_slab_color_gate_filter_core_defines.svh
// Assertion macros for the checker file of this block.
`ifndef DEPTH_SLAB_COLOR_GATE_FILTER_CORE_DEFINES_SVH
`define DEPTH_SLAB_COLOR_GATE_FILTER_CORE_DEFINES_SVH

// Property checked on every rising clock edge outside reset.
`define DSCGF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define DSCGF_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/dscgf_pkg.sv
`default_nettype none

package dscgf_pkg;

   localparam int COLOR_W     = 8;
   localparam int NORM_W      = 16;
   localparam int SLAB_W      = 16;
   localparam int RADIUS_W    = 9;
   localparam int DIST_W      = 18;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SLAB_WIDTH     = 3'd0,
      CSR_COLOR_GATE_ON  = 3'd1,
      CSR_COLORS_PRESENT = 3'd2,
      CSR_TARGET_RED     = 3'd3,
      CSR_TARGET_GREEN   = 3'd4,
      CSR_TARGET_BLUE    = 3'd5,
      CSR_COLOR_RADIUS   = 3'd6
   } csr_index_type;

   localparam logic [SLAB_W-1:0]   SLAB_WIDTH_RESET     = 16'd500;
   localparam logic                COLOR_GATE_ON_RESET  = 1'b0;
   localparam logic                COLORS_PRESENT_RESET = 1'b1;
   localparam logic [COLOR_W-1:0]  TARGET_RESET         = 8'd0;
   localparam logic [RADIUS_W-1:0] COLOR_RADIUS_RESET   = 9'd51;
   localparam logic [DIST_W-1:0]   RADIUS_SQ_RESET      = 18'd2601;

endpackage

`default_nettype wire

>>> design/dscgf_chan_if.sv
`default_nettype none

interface dscgf_req_if
   import dscgf_pkg::*;
#(
   parameter int COORD_BITS = 20
);
   logic                      valid;
   logic                      ready;
   logic                      req_type;
   logic signed [COORD_BITS-1:0] pos_x;
   logic signed [COORD_BITS-1:0] pos_y;
   logic signed [COORD_BITS-1:0] pos_z;
   logic [COLOR_W-1:0]        red;
   logic [COLOR_W-1:0]        green;
   logic [COLOR_W-1:0]        blue;
   logic signed [NORM_W-1:0]  norm_x;
   logic signed [NORM_W-1:0]  norm_y;
   logic signed [NORM_W-1:0]  norm_z;
   logic                      final_point;

   modport source (
      output valid, req_type, pos_x, pos_y, pos_z, red, green, blue,
             norm_x, norm_y, norm_z, final_point,
      input  ready
   );
   modport sink (
      input  valid, req_type, pos_x, pos_y, pos_z, red, green, blue,
             norm_x, norm_y, norm_z, final_point,
      output ready
   );
endinterface

interface dscgf_rsp_if
   import dscgf_pkg::*;
#(
   parameter int COORD_BITS = 20
);
   logic                      valid;
   logic                      ready;
   logic signed [COORD_BITS-1:0] out_x;
   logic signed [COORD_BITS-1:0] out_y;
   logic signed [COORD_BITS-1:0] out_z;
   logic [COLOR_W-1:0]        out_red;
   logic [COLOR_W-1:0]        out_green;
   logic [COLOR_W-1:0]        out_blue;
   logic signed [NORM_W-1:0]  out_norm_x;
   logic signed [NORM_W-1:0]  out_norm_y;
   logic signed [NORM_W-1:0]  out_norm_z;
   logic                      end_of_cloud;
   logic                      nothing_kept;

   modport source (
      output valid, out_x, out_y, out_z, out_red, out_green, out_blue,
             out_norm_x, out_norm_y, out_norm_z, end_of_cloud, nothing_kept,
      input  ready
   );
   modport sink (
      input  valid, out_x, out_y, out_z, out_red, out_green, out_blue,
             out_norm_x, out_norm_y, out_norm_z, end_of_cloud, nothing_kept,
      output ready
   );
endinterface

`default_nettype wire

>>> design/depth_slab_color_gate_filter_core.sv
// Channel    Port       Direction  Contents
// request    req_chan   in         pass type, point, colour, normal, last-of-pass flag
// result     rsp_chan   out        kept point or end marker with empty flag
// config     csr_*      in         register write: enable, index, data
//
// One item per cycle is sustained while rsp_chan takes results. An item is taken
// into the input register at its accepting edge; any result it gives is loaded
// into the result register when the item moves on, and offered on rsp_chan.
// Reset clears both valid flags and resets the config and depth tracking state.
// A stalled result holds the result register, and the input register stalls
// behind it, so back-pressure reaches req_chan.ready in the same cycle.
`default_nettype none

module depth_slab_color_gate_filter_core
   import dscgf_pkg::*;
#(
   parameter int COORD_BITS = 20
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   dscgf_req_if.sink                  req_chan,
   dscgf_rsp_if.source                rsp_chan,
   input  wire logic                  csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int SUM_W = ((COORD_BITS > SLAB_W) ? COORD_BITS : SLAB_W) + 2;
   localparam logic signed [COORD_BITS-1:0] MAX_DEPTH = {1'b0, {(COORD_BITS-1){1'b1}}};

   // Configuration registers.
   logic [SLAB_W-1:0]   slab_width_ff;
   logic                color_gate_on_ff;
   logic                colors_present_ff;
   logic [COLOR_W-1:0]  target_red_ff;
   logic [COLOR_W-1:0]  target_green_ff;
   logic [COLOR_W-1:0]  target_blue_ff;
   logic [DIST_W-1:0]   radius_sq_ff;
   logic [DIST_W-1:0]   radius_sq_in;

   // Cloud state.
   logic signed [COORD_BITS-1:0] nearest_ff, nearest_in;
   logic                         any_kept_ff, any_kept_in;

   // Input register.
   logic                         s1_valid_ff, s1_valid_in;
   logic                         s1_type_ff;
   logic signed [COORD_BITS-1:0] s1_x_ff, s1_y_ff, s1_z_ff;
   logic [COLOR_W-1:0]           s1_red_ff, s1_green_ff, s1_blue_ff;
   logic signed [NORM_W-1:0]     s1_nx_ff, s1_ny_ff, s1_nz_ff;
   logic                         s1_final_ff;

   // Result register.
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [COORD_BITS-1:0] rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic [COLOR_W-1:0]           rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic signed [NORM_W-1:0]     rsp_nx_ff, rsp_ny_ff, rsp_nz_ff;
   logic                         rsp_end_ff, rsp_empty_ff;

   logic                         out_free;
   logic                         advance;
   logic                         load_s1;
   logic                         in_slab;
   logic                         gate_pass;
   logic                         keep;
   logic                         emit;
   logic signed [SUM_W-1:0]      z_wide;
   logic signed [SUM_W-1:0]      near_wide;
   logic signed [SUM_W-1:0]      upper_wide;
   logic signed [COLOR_W:0]      d_red, d_green, d_blue;
   logic signed [DIST_W-1:0]     sq_red, sq_green, sq_blue;
   logic [DIST_W-1:0]            dist_sq;

   assign radius_sq_in = DIST_W'(csr_wdata[RADIUS_W-1:0]) * DIST_W'(csr_wdata[RADIUS_W-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         slab_width_ff     <= SLAB_WIDTH_RESET;
         color_gate_on_ff  <= COLOR_GATE_ON_RESET;
         colors_present_ff <= COLORS_PRESENT_RESET;
         target_red_ff     <= TARGET_RESET;
         target_green_ff   <= TARGET_RESET;
         target_blue_ff    <= TARGET_RESET;
         radius_sq_ff      <= RADIUS_SQ_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_SLAB_WIDTH:     slab_width_ff     <= csr_wdata[SLAB_W-1:0];
            CSR_COLOR_GATE_ON:  color_gate_on_ff  <= csr_wdata[0];
            CSR_COLORS_PRESENT: colors_present_ff <= csr_wdata[0];
            CSR_TARGET_RED:     target_red_ff     <= csr_wdata[COLOR_W-1:0];
            CSR_TARGET_GREEN:   target_green_ff   <= csr_wdata[COLOR_W-1:0];
            CSR_TARGET_BLUE:    target_blue_ff    <= csr_wdata[COLOR_W-1:0];
            CSR_COLOR_RADIUS:   radius_sq_ff      <= radius_sq_in;
            default: ;
         endcase
      end
   end

   // Handshake: the input register moves on whenever the result register can
   // take a new value, whether or not this item gives a result.
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign advance        = s1_valid_ff && out_free;
   assign req_chan.ready = !s1_valid_ff || out_free;
   assign load_s1        = req_chan.valid && req_chan.ready;

   // Slab test in a width that holds nearest plus the slab without overflow.
   assign z_wide     = SUM_W'(s1_z_ff);
   assign near_wide  = SUM_W'(nearest_ff);
   assign upper_wide = near_wide + signed'(SUM_W'(slab_width_ff));
   assign in_slab    = (z_wide >= near_wide) && (z_wide <= upper_wide);

   assign d_red    = signed'({1'b0, s1_red_ff})   - signed'({1'b0, target_red_ff});
   assign d_green  = signed'({1'b0, s1_green_ff}) - signed'({1'b0, target_green_ff});
   assign d_blue   = signed'({1'b0, s1_blue_ff})  - signed'({1'b0, target_blue_ff});
   assign sq_red   = DIST_W'(d_red) * DIST_W'(d_red);
   assign sq_green = DIST_W'(d_green) * DIST_W'(d_green);
   assign sq_blue  = DIST_W'(d_blue) * DIST_W'(d_blue);
   assign dist_sq  = unsigned'(sq_red) + unsigned'(sq_green) + unsigned'(sq_blue);
   assign gate_pass = !(color_gate_on_ff && colors_present_ff) || (dist_sq <= radius_sq_ff);

   assign keep = s1_type_ff && in_slab && gate_pass;
   assign emit = s1_type_ff && (keep || s1_final_ff);

   always_comb begin
      s1_valid_in  = load_s1 ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      rsp_valid_in = out_free ? (advance && emit) : rsp_valid_ff;
      nearest_in   = nearest_ff;
      any_kept_in  = any_kept_ff;
      if (advance) begin
         if (!s1_type_ff) begin
            if (s1_z_ff < nearest_ff) begin
               nearest_in = s1_z_ff;
            end
         end else if (s1_final_ff) begin
            nearest_in  = MAX_DEPTH;
            any_kept_in = 1'b0;
         end else if (keep) begin
            any_kept_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         nearest_ff   <= MAX_DEPTH;
         any_kept_ff  <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         nearest_ff   <= nearest_in;
         any_kept_ff  <= any_kept_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_s1) begin
         s1_type_ff  <= req_chan.req_type;
         s1_x_ff     <= req_chan.pos_x;
         s1_y_ff     <= req_chan.pos_y;
         s1_z_ff     <= req_chan.pos_z;
         s1_red_ff   <= req_chan.red;
         s1_green_ff <= req_chan.green;
         s1_blue_ff  <= req_chan.blue;
         s1_nx_ff    <= req_chan.norm_x;
         s1_ny_ff    <= req_chan.norm_y;
         s1_nz_ff    <= req_chan.norm_z;
         s1_final_ff <= req_chan.final_point;
      end
   end

   // A rejected final item leaves an end marker with all point fields zero.
   always_ff @(posedge clock) begin
      if (advance && emit) begin
         rsp_x_ff     <= keep ? s1_x_ff : '0;
         rsp_y_ff     <= keep ? s1_y_ff : '0;
         rsp_z_ff     <= keep ? s1_z_ff : '0;
         rsp_red_ff   <= (keep && colors_present_ff) ? s1_red_ff : '0;
         rsp_green_ff <= (keep && colors_present_ff) ? s1_green_ff : '0;
         rsp_blue_ff  <= (keep && colors_present_ff) ? s1_blue_ff : '0;
         rsp_nx_ff    <= keep ? s1_nx_ff : '0;
         rsp_ny_ff    <= keep ? s1_ny_ff : '0;
         rsp_nz_ff    <= keep ? s1_nz_ff : '0;
         rsp_end_ff   <= s1_final_ff;
         rsp_empty_ff <= s1_final_ff && !keep && !any_kept_ff;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.out_x        = rsp_x_ff;
   assign rsp_chan.out_y        = rsp_y_ff;
   assign rsp_chan.out_z        = rsp_z_ff;
   assign rsp_chan.out_red      = rsp_red_ff;
   assign rsp_chan.out_green    = rsp_green_ff;
   assign rsp_chan.out_blue     = rsp_blue_ff;
   assign rsp_chan.out_norm_x   = rsp_nx_ff;
   assign rsp_chan.out_norm_y   = rsp_ny_ff;
   assign rsp_chan.out_norm_z   = rsp_nz_ff;
   assign rsp_chan.end_of_cloud = rsp_end_ff;
   assign rsp_chan.nothing_kept = rsp_empty_ff;

endmodule

`default_nettype wire

>>> design/dscgf_checker.sv
`default_nettype none
`include "depth_slab_color_gate_filter_core_defines.svh"

module dscgf_checker
   import dscgf_pkg::*;
#(
   parameter int COORD_BITS = 20
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire logic [COORD_BITS-1:0] rsp_x,
   input wire logic [COORD_BITS-1:0] rsp_z,
   input wire logic [NORM_W-1:0]     rsp_norm_x,
   input wire logic                  rsp_end,
   input wire logic                  rsp_empty
);

   // Set once a point of the current cloud has been delivered.
   logic kept_seen_ff;
   logic kept_seen_in;
   logic rsp_take;

   assign rsp_take = rsp_valid && rsp_ready;

   always_comb begin
      kept_seen_in = kept_seen_ff;
      if (rsp_take) begin
         kept_seen_in = !rsp_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kept_seen_ff <= 1'b0;
      end else begin
         kept_seen_ff <= kept_seen_in;
      end
   end

   `DSCGF_ASSERT_ALWAYS(a_idle_after_reset, clock, reset |=> !rsp_valid, "result valid after reset")
   `DSCGF_ASSERT(a_hold_on_stall, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_z), "stalled result changed")
   `DSCGF_ASSERT(a_empty_is_end, clock, reset, rsp_valid && rsp_empty |-> rsp_end && rsp_x == '0 && rsp_norm_x == '0, "empty flag off an end marker")
   `DSCGF_ASSERT(a_empty_after_kept, clock, reset, rsp_take && rsp_empty |-> !kept_seen_ff, "empty flag after a kept point")

endmodule

bind depth_slab_color_gate_filter_core dscgf_checker #(
   .COORD_BITS (COORD_BITS)
) u_dscgf_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_x      (rsp_chan.out_x),
   .rsp_z      (rsp_chan.out_z),
   .rsp_norm_x (rsp_chan.out_norm_x),
   .rsp_end    (rsp_chan.end_of_cloud),
   .rsp_empty  (rsp_chan.nothing_kept)
);

`default_nettype wire

>>> tb/sv/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import dscgf_pkg::*;

   localparam int COORD_BITS = 20;
   localparam int Z_MAX = (1 << (COORD_BITS - 1)) - 1;
   localparam int Z_MIN = -(1 << (COORD_BITS - 1));
   localparam int N_MAX = 16384;
   localparam int RANDOM_POINTS = 1300;

   typedef struct {
      logic                         is_filter;
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic signed [COORD_BITS-1:0] z;
      logic [COLOR_W-1:0]           red;
      logic [COLOR_W-1:0]           green;
      logic [COLOR_W-1:0]           blue;
      logic signed [NORM_W-1:0]     nx;
      logic signed [NORM_W-1:0]     ny;
      logic signed [NORM_W-1:0]     nz;
      logic                         last;
   } point_type;

   typedef struct {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic signed [COORD_BITS-1:0] z;
      logic [COLOR_W-1:0]           red;
      logic [COLOR_W-1:0]           green;
      logic [COLOR_W-1:0]           blue;
      logic signed [NORM_W-1:0]     nx;
      logic signed [NORM_W-1:0]     ny;
      logic signed [NORM_W-1:0]     nz;
      logic                         end_of_cloud;
      logic                         nothing_kept;
   } kept_type;

   typedef struct {
      logic [SLAB_W-1:0]   slab;
      logic                gate_on;
      logic                colors_on;
      logic [COLOR_W-1:0]  tr;
      logic [COLOR_W-1:0]  tg;
      logic [COLOR_W-1:0]  tb;
      logic [RADIUS_W-1:0] radius;
   } settings_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   csr_index_type csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   dscgf_req_if #(.COORD_BITS(COORD_BITS)) req_chan ();
   dscgf_rsp_if #(.COORD_BITS(COORD_BITS)) rsp_chan ();

   depth_slab_color_gate_filter_core #(.COORD_BITS(COORD_BITS)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Own copy of the block's registers and depth tracking state.
   settings_type cfg;
   logic signed [COORD_BITS-1:0] nearest_depth;
   logic any_kept;

   point_type points_to_send[$];
   kept_type  kept_points[$];
   point_type on_wire;

   int points_issued = 0;
   int points_accepted = 0;
   int points_emitted = 0;
   int clouds_closed = 0;
   int settings_count = 0;
   int mismatches = 0;
   int burst_left = 0;
   int gap_left = 0;
   int hold_left = 0;
   int stretch_left = 0;
   int ready_mode = 0;
   logic long_hold_done = 1'b0;

   function automatic void filter_point(input point_type p);
      kept_type r;
      logic keep;
      longint top;
      int dr, dg, db;
      if (!p.is_filter) begin
         if (p.z < nearest_depth) nearest_depth = p.z;
         return;
      end
      top = longint'(nearest_depth) + longint'(cfg.slab);
      keep = (p.z >= nearest_depth) && (longint'(p.z) <= top);
      if (keep && cfg.gate_on && cfg.colors_on) begin
         dr = int'(p.red) - int'(cfg.tr);
         dg = int'(p.green) - int'(cfg.tg);
         db = int'(p.blue) - int'(cfg.tb);
         keep = (dr * dr + dg * dg + db * db) <= int'(cfg.radius) * int'(cfg.radius);
      end
      if (!keep && !p.last) return;
      r = '{default: 0};
      if (keep) begin
         any_kept = 1'b1;
         r.x = p.x;
         r.y = p.y;
         r.z = p.z;
         if (cfg.colors_on) begin
            r.red = p.red;
            r.green = p.green;
            r.blue = p.blue;
         end
         r.nx = p.nx;
         r.ny = p.ny;
         r.nz = p.nz;
      end
      if (p.last) begin
         r.end_of_cloud = 1'b1;
         r.nothing_kept = !any_kept;
         nearest_depth = COORD_BITS'(Z_MAX);
         any_kept = 1'b0;
      end
      kept_points.insert(kept_points.size(), r);
   endfunction

   function automatic void compare_field(string name, logic signed [63:0] want,
                                         logic signed [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   function automatic int clamp(int v, int lo, int hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic int random_coord();
      return int'($urandom_range(0, 2 * Z_MAX + 1)) + Z_MIN;
   endfunction

   function automatic point_type make_point(int filt, int x, int y, int z, int r, int g, int b,
                                            int nx, int ny, int nz, int last);
      point_type p;
      p.is_filter = filt[0];
      p.x = x[COORD_BITS-1:0];
      p.y = y[COORD_BITS-1:0];
      p.z = z[COORD_BITS-1:0];
      p.red = r[7:0];
      p.green = g[7:0];
      p.blue = b[7:0];
      p.nx = nx[15:0];
      p.ny = ny[15:0];
      p.nz = nz[15:0];
      p.last = last[0];
      return p;
   endfunction

   function automatic point_type random_point(logic filt, int z);
      return make_point(int'(filt), random_coord(), random_coord(), z,
                        $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                        int'($urandom_range(0, 2 * N_MAX)) - N_MAX,
                        int'($urandom_range(0, 2 * N_MAX)) - N_MAX,
                        int'($urandom_range(0, 2 * N_MAX)) - N_MAX, 0);
   endfunction

   // A colour component close enough to the target that the gate often passes.
   function automatic logic [7:0] near_color(logic [7:0] target, int reach);
      int v;
      v = int'(target) + int'($urandom_range(0, 2 * reach)) - reach;
      v = clamp(v, 0, 255);
      return v[7:0];
   endfunction

   function automatic logic [7:0] random_target();
      case ($urandom_range(0, 5))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic settings_type random_settings();
      settings_type s;
      case ($urandom_range(0, 4))
         0: s.slab = 16'd1;
         1: s.slab = 16'hFFFF;
         2: s.slab = 16'($urandom_range(1, 65535));
         default: s.slab = 16'($urandom_range(1, 2000));
      endcase
      s.gate_on = ($urandom_range(0, 2) != 0);
      s.colors_on = ($urandom_range(0, 4) != 0);
      s.tr = random_target();
      s.tg = random_target();
      s.tb = random_target();
      case ($urandom_range(0, 5))
         0: s.radius = 9'd0;
         1: s.radius = 9'd442;
         2: s.radius = 9'($urandom_range(0, 442));
         default: s.radius = 9'($urandom_range(20, 160));
      endcase
      return s;
   endfunction

   task automatic send_point(input point_type p);
      points_to_send.insert(points_to_send.size(), p);
      points_issued++;
   endtask

   task automatic apply_settings(input settings_type s);
      csr_we <= 1'b1;
      csr_index <= CSR_SLAB_WIDTH;
      csr_wdata <= s.slab;
      @(posedge clock);
      csr_index <= CSR_COLOR_GATE_ON;
      csr_wdata <= 16'(s.gate_on);
      @(posedge clock);
      csr_index <= CSR_COLORS_PRESENT;
      csr_wdata <= 16'(s.colors_on);
      @(posedge clock);
      csr_index <= CSR_TARGET_RED;
      csr_wdata <= 16'(s.tr);
      @(posedge clock);
      csr_index <= CSR_TARGET_GREEN;
      csr_wdata <= 16'(s.tg);
      @(posedge clock);
      csr_index <= CSR_TARGET_BLUE;
      csr_wdata <= 16'(s.tb);
      @(posedge clock);
      csr_index <= CSR_COLOR_RADIUS;
      csr_wdata <= 16'(s.radius);
      @(posedge clock);
      csr_we <= 1'b0;
      cfg = s;
      settings_count++;
   endtask

   // Items that cause no result may still be in the two register stages once the
   // last expected result has arrived, so the task waits on before it returns.
   task automatic wait_idle();
      do @(posedge clock);
      while (points_accepted != points_issued || kept_points.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // One cloud: a measure pass around a random depth, then a filter pass whose
   // depths mostly fall inside or on the edges of the expected slab.
   task automatic make_cloud(int n_meas, int n_filt, logic with_final);
      int base, z, lowest, span, reach, k;
      point_type p;
      lowest = Z_MAX;
      base = int'($urandom_range(0, 1000000)) - 520000;
      for (k = 0; k < n_meas; k++) begin
         z = clamp(base + int'($urandom_range(0, 4000)), Z_MIN, Z_MAX);
         if ($urandom_range(0, 19) == 0) z = random_coord();
         if (z < lowest) lowest = z;
         p = random_point(1'b0, z);
         p.last = (k == n_meas - 1) ? 1'($urandom_range(0, 1)) : 1'b0;
         send_point(p);
      end
      span = int'(cfg.slab);
      reach = int'(cfg.radius) * 2 / 3 + 1;
      for (k = 0; k < n_filt; k++) begin
         case ($urandom_range(0, 9))
            0: z = random_coord();
            1: begin
               case ($urandom_range(0, 3))
                  0: z = lowest - 1;
                  1: z = lowest;
                  2: z = lowest + span;
                  default: z = lowest + span + 1;
               endcase
            end
            2: z = lowest + int'($urandom_range(0, 2 * span + 4)) - 2;
            default: z = lowest + int'($urandom_range(0, span));
         endcase
         p = random_point(1'b1, clamp(z, Z_MIN, Z_MAX));
         if (cfg.gate_on && $urandom_range(0, 4) < 3) begin
            p.red = near_color(cfg.tr, reach);
            p.green = near_color(cfg.tg, reach);
            p.blue = near_color(cfg.tb, reach);
         end
         p.last = with_final && (k == n_filt - 1);
         send_point(p);
      end
   endtask

   // Sender: bursts of random length separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            filter_point(on_wire);
            points_accepted++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_chan.valid <= 1'b0;
            end else if (points_to_send.size() > 0) begin
               on_wire = points_to_send.pop_front();
               req_chan.req_type <= on_wire.is_filter;
               req_chan.pos_x <= on_wire.x;
               req_chan.pos_y <= on_wire.y;
               req_chan.pos_z <= on_wire.z;
               req_chan.red <= on_wire.red;
               req_chan.green <= on_wire.green;
               req_chan.blue <= on_wire.blue;
               req_chan.norm_x <= on_wire.nx;
               req_chan.norm_y <= on_wire.ny;
               req_chan.norm_z <= on_wire.nz;
               req_chan.final_point <= on_wire.last;
               req_chan.valid <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 30);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: stall pattern that changes from stretch to stretch, plus one long hold.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         hold_left = 0;
         stretch_left = 0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else if (!long_hold_done && points_accepted >= 500 && points_to_send.size() > 40) begin
         // Long enough for the result and input registers to fill and stall the sender.
         long_hold_done = 1'b1;
         hold_left = 150;
         rsp_chan.ready <= 1'b0;
      end else begin
         if (stretch_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            stretch_left = $urandom_range(10, 80);
         end else begin
            stretch_left--;
         end
         case (ready_mode)
            0: rsp_chan.ready <= 1'b1;
            1: rsp_chan.ready <= 1'($urandom_range(0, 1));
            2: rsp_chan.ready <= (stretch_left % 4 == 0);
            default: rsp_chan.ready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   always @(posedge clock) begin
      kept_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (kept_points.size() == 0) begin
            $display("%0t: unexpected item: expected none, got x=%0d y=%0d z=%0d end=%0b",
                     $time, rsp_chan.out_x, rsp_chan.out_y, rsp_chan.out_z,
                     rsp_chan.end_of_cloud);
            mismatches++;
         end else begin
            want = kept_points.pop_front();
            compare_field("out_x", want.x, rsp_chan.out_x);
            compare_field("out_y", want.y, rsp_chan.out_y);
            compare_field("out_z", want.z, rsp_chan.out_z);
            compare_field("out_red", want.red, rsp_chan.out_red);
            compare_field("out_green", want.green, rsp_chan.out_green);
            compare_field("out_blue", want.blue, rsp_chan.out_blue);
            compare_field("out_norm_x", want.nx, rsp_chan.out_norm_x);
            compare_field("out_norm_y", want.ny, rsp_chan.out_norm_y);
            compare_field("out_norm_z", want.nz, rsp_chan.out_norm_z);
            compare_field("end_of_cloud", want.end_of_cloud, rsp_chan.end_of_cloud);
            compare_field("nothing_kept", want.nothing_kept, rsp_chan.nothing_kept);
            points_emitted++;
            if (want.end_of_cloud) clouds_closed++;
         end
      end
   end

   initial begin
      #2_000_000;
      $display("%0t: timed out with %0d items still expected", $time, kept_points.size());
      $display("FAIL depth_slab_color_gate_filter_core");
      $finish;
   end

   initial begin
      settings_type s;
      int random_sent, nm, nf;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_SLAB_WIDTH;
      csr_wdata = '0;
      req_chan.valid = 1'b0;
      req_chan.req_type = 1'b0;
      req_chan.pos_x = '0;
      req_chan.pos_y = '0;
      req_chan.pos_z = '0;
      req_chan.red = '0;
      req_chan.green = '0;
      req_chan.blue = '0;
      req_chan.norm_x = '0;
      req_chan.norm_y = '0;
      req_chan.norm_z = '0;
      req_chan.final_point = 1'b0;
      rsp_chan.ready = 1'b0;
      cfg = '{slab: SLAB_WIDTH_RESET, gate_on: COLOR_GATE_ON_RESET,
              colors_on: COLORS_PRESENT_RESET, tr: TARGET_RESET, tg: TARGET_RESET,
              tb: TARGET_RESET, radius: COLOR_RADIUS_RESET};
      nearest_depth = COORD_BITS'(Z_MAX);
      any_kept = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset settings. Filter points with no measure pass only pass at the
      // maximum depth; a rejected last point closes the cloud with a marker.
      send_point(make_point(1, Z_MIN, Z_MAX, Z_MAX, 255, 255, 255, N_MAX, -N_MAX, 0, 0));
      send_point(make_point(1, 1, 2, 0, 0, 0, 0, 0, 0, 0, 0));
      send_point(make_point(1, 3, 4, 5, 9, 9, 9, 1, 1, 1, 1));
      send_point(make_point(1, 6, 7, Z_MIN, 1, 1, 1, -1, -1, -1, 1));
      send_point(make_point(0, 10, 10, 1000, 0, 0, 0, 0, 0, 0, 0));
      send_point(make_point(0, 11, 11, 300, 0, 0, 0, 0, 0, 0, 0));
      send_point(make_point(0, 12, 12, 700, 0, 0, 0, 0, 0, 0, 1));
      send_point(make_point(1, -5, 5, 300, 10, 20, 30, 100, 200, 300, 0));
      send_point(make_point(1, -6, 6, 800, 40, 50, 60, -100, -200, -300, 0));
      send_point(make_point(1, -7, 7, 801, 1, 2, 3, 4, 5, 6, 0));
      send_point(make_point(1, -8, 8, 299, 1, 2, 3, 4, 5, 6, 0));
      send_point(make_point(1, -9, 9, 550, 70, 80, 90, 7, 8, 9, 1));
      wait_idle();

      // A zero radius lets only the exact target colour through.
      apply_settings('{slab: 16'd500, gate_on: 1'b1, colors_on: 1'b1, tr: 8'd255, tg: 8'd0,
                       tb: 8'd128, radius: 9'd0});
      send_point(make_point(0, 0, 0, Z_MIN, 0, 0, 0, 0, 0, 0, 0));
      send_point(make_point(1, 21, 22, Z_MIN, 255, 0, 128, 1, 2, 3, 0));
      send_point(make_point(1, 23, 24, Z_MIN, 254, 0, 128, 1, 2, 3, 0));
      send_point(make_point(1, 25, 26, Z_MIN + 501, 255, 0, 128, 1, 2, 3, 1));
      wait_idle();

      // Without colours the gate is skipped and the colour outputs are zero.
      apply_settings('{slab: 16'd500, gate_on: 1'b1, colors_on: 1'b0, tr: 8'd255, tg: 8'd0,
                       tb: 8'd128, radius: 9'd0});
      send_point(make_point(0, 0, 0, 10, 0, 0, 0, 0, 0, 0, 0));
      send_point(make_point(1, 31, 32, 10, 1, 2, 3, 4, 5, 6, 0));
      send_point(make_point(1, 33, 34, Z_MAX, 1, 2, 3, 4, 5, 6, 1));
      wait_idle();

      // Zero slab width keeps only the nearest depth; an oversized radius passes all.
      apply_settings('{slab: 16'd0, gate_on: 1'b1, colors_on: 1'b1, tr: 8'd255, tg: 8'd255,
                       tb: 8'd255, radius: 9'd511});
      send_point(make_point(0, 0, 0, 50, 0, 0, 0, 0, 0, 0, 0));
      send_point(make_point(1, 41, 42, 50, 0, 0, 0, N_MAX, N_MAX, N_MAX, 0));
      send_point(make_point(1, 43, 44, 51, 0, 0, 0, 0, 0, 0, 0));
      send_point(make_point(1, 45, 46, 50, 128, 64, 32, -N_MAX, -N_MAX, -N_MAX, 1));
      wait_idle();

      // Widest slab near the top of the depth range.
      apply_settings('{slab: 16'hFFFF, gate_on: 1'b0, colors_on: 1'b1, tr: 8'd0, tg: 8'd0,
                       tb: 8'd0, radius: 9'd442});
      send_point(make_point(0, 0, 0, Z_MAX - 10, 0, 0, 0, 0, 0, 0, 0));
      send_point(make_point(1, Z_MAX, Z_MIN, Z_MAX, 200, 100, 50, 5, 6, 7, 1));
      wait_idle();

      // Mostly well-formed clouds with random content; some lack a measure pass
      // or a closing item, and some points are placed anywhere in depth.
      random_sent = 0;
      while (random_sent < RANDOM_POINTS) begin
         s = random_settings();
         apply_settings(s);
         repeat ($urandom_range(2, 5)) begin
            nm = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 30);
            nf = $urandom_range(1, 40);
            make_cloud(nm, nf, $urandom_range(0, 9) != 0);
            random_sent += nm + nf;
         end
         wait_idle();
      end
      repeat (6) @(posedge clock);

      $display("Sent %0d points under %0d settings, checked %0d results, %0d end markers.",
               points_accepted, settings_count, points_emitted, clouds_closed);
      $display("Long result stall with the input backed up: %s",
               long_hold_done ? "applied" : "not reached");
      if (mismatches == 0) begin
         $display("PASS depth_slab_color_gate_filter_core");
      end else begin
         $display("FAIL depth_slab_color_gate_filter_core");
      end
      $finish;
   end

endmodule
